### sv/mer_pkg.sv
// Shared types, widths and the control store of the midpoint ellipse rasterizer.
// Used by mer_datapath and midpoint_ellipse_rasterizer; depends on nothing else.
package mer_pkg;

  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 9;

  localparam int OFFX_W = COORD_BITS;          // offset x, never negative
  localparam int OFFY_W = RADIUS_BITS + 2;     // offset y, signed, drops to -1
  localparam int OUT_W  = 12;                  // wrapped output coordinate
  localparam int R2_W   = 2 * RADIUS_BITS;     // squared radius
  localparam int D_W    = 48;                  // decision value, scaled by four
  localparam int P_W    = 48;                  // product register
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 19;
  localparam int SH_W   = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 4 * OUT_W;

  // control store addresses
  localparam int UA_W = 5;
  localparam logic [UA_W-1:0] UA_START   = UA_W'(0);
  localparam logic [UA_W-1:0] UA_R1      = UA_W'(5);
  localparam logic [UA_W-1:0] UA_R1_CMP  = UA_W'(10);
  localparam logic [UA_W-1:0] UA_R2      = UA_W'(17);
  localparam logic [UA_W-1:0] UA_FIN     = UA_W'(22);

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_RY2_X,
    MUL_RX2_Y,
    MUL_RY2_TX,
    MUL_P_TX,
    MUL_RX2_TY,
    MUL_P_TY,
    MUL_RX2_RY2
  } mer_mul_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_CLR,
    ACC_ADD,
    ACC_SUB
  } mer_acc_t;

  typedef enum logic [1:0] {
    SRC_P,
    SRC_RX2,
    SRC_RY2
  } mer_src_t;

  typedef enum logic [1:0] {
    XY_NONE,
    XY_R1,
    XY_R2,
    XY_ENTER
  } mer_xy_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_BR,
    JMP_NO_ENTER
  } mer_jmp_t;

  typedef struct packed {
    mer_mul_t        mul;
    mer_acc_t        acc;
    mer_src_t        src;
    logic [SH_W-1:0] sh;
    logic            ld_rx2;
    logic            ld_ry2;
    logic            ld_q;
    mer_xy_t         xy;
    mer_jmp_t        jmp;
    logic [UA_W-1:0] target;
    logic            done;
  } mer_cw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic r2;      // walk is in region two
    logic br;      // branch flag latched by the last x/y step
    logic enter;   // region two entry condition holds
    logic y_neg;   // offset y below zero
  } mer_stat_t;

  localparam mer_cw_t CW_NOP = '{
    mul: MUL_NONE, acc: ACC_NONE, src: SRC_P, sh: '0,
    ld_rx2: 1'b0, ld_ry2: 1'b0, ld_q: 1'b0,
    xy: XY_NONE, jmp: JMP_NONE, target: '0, done: 1'b0
  };

  // Control store. Start: squares and initial decision. Region one: step,
  // update, test for region two and rebuild the decision there. Region two:
  // step and update. The final word hands the result over.
  function automatic mer_cw_t mer_ucode(input logic [UA_W-1:0] addr);
    mer_cw_t cw;
    cw = CW_NOP;
    case (addr)
      UA_W'(0):  cw.mul = MUL_RX_RX;
      UA_W'(1):  begin cw.ld_rx2 = 1'b1; cw.mul = MUL_RY_RY; end
      UA_W'(2):  begin
        cw.ld_ry2 = 1'b1; cw.mul = MUL_RX2_RY;
        cw.acc = ACC_ADD; cw.src = SRC_RX2; cw.sh = SH_W'(0);
      end
      UA_W'(3):  begin cw.acc = ACC_SUB; cw.src = SRC_P; cw.sh = SH_W'(2); end
      UA_W'(4):  begin
        cw.acc = ACC_ADD; cw.src = SRC_RY2; cw.sh = SH_W'(2); cw.done = 1'b1;
      end
      // region one
      UA_W'(5):  cw.xy = XY_R1;
      UA_W'(6):  cw.mul = MUL_RY2_X;
      UA_W'(7):  begin
        cw.mul = MUL_RX2_Y; cw.ld_q = 1'b1;
        cw.acc = ACC_ADD; cw.src = SRC_P; cw.sh = SH_W'(3);
      end
      UA_W'(8):  begin
        cw.acc = ACC_ADD; cw.src = SRC_RY2; cw.sh = SH_W'(2);
        cw.jmp = JMP_BR; cw.target = UA_R1_CMP;
      end
      UA_W'(9):  begin cw.acc = ACC_SUB; cw.src = SRC_P; cw.sh = SH_W'(3); end
      UA_W'(10): begin cw.jmp = JMP_NO_ENTER; cw.target = UA_FIN; end
      UA_W'(11): begin cw.xy = XY_ENTER; cw.acc = ACC_CLR; cw.mul = MUL_RY2_TX; end
      UA_W'(12): cw.mul = MUL_P_TX;
      UA_W'(13): begin
        cw.acc = ACC_ADD; cw.src = SRC_P; cw.sh = SH_W'(0); cw.mul = MUL_RX2_TY;
      end
      UA_W'(14): cw.mul = MUL_P_TY;
      UA_W'(15): begin
        cw.acc = ACC_ADD; cw.src = SRC_P; cw.sh = SH_W'(2); cw.mul = MUL_RX2_RY2;
      end
      UA_W'(16): begin
        cw.acc = ACC_SUB; cw.src = SRC_P; cw.sh = SH_W'(2); cw.done = 1'b1;
      end
      // region two
      UA_W'(17): cw.xy = XY_R2;
      UA_W'(18): cw.mul = MUL_RX2_Y;
      UA_W'(19): begin
        cw.acc = ACC_SUB; cw.src = SRC_P; cw.sh = SH_W'(3); cw.mul = MUL_RY2_X;
      end
      UA_W'(20): begin
        cw.acc = ACC_ADD; cw.src = SRC_RX2; cw.sh = SH_W'(2);
        cw.jmp = JMP_BR; cw.target = UA_FIN;
      end
      UA_W'(21): begin cw.acc = ACC_ADD; cw.src = SRC_P; cw.sh = SH_W'(3); end
      default:   cw.done = 1'b1;
    endcase
    return cw;
  endfunction

endpackage

### sv/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer: handshakes, microcode sequencer,
// result register. Depends on mer_pkg and mer_datapath.
//
// Usage: send a start item (in_tuser = 0) with center and both semi-axes in
// in_tdata, then advance items (in_tuser = 1). Each item gives exactly one result
// item. An advance returns the four mirror points of the current offset with
// out_tuser = 1 and then moves the walk one step; out_tlast marks the final group.
// Start items and advances while no ellipse is in progress return all zeros.
// A start during a walk abandons it.
// Timing: a small control store drives one shared multiplier and an adder, one
// word per cycle while the final word is not held by a stall; in_tready is high
// whenever the sequencer is idle. An idle advance runs only the final word; the
// step that enters region two runs more words, as the decision is rebuilt
// through a chain of multiplies. The result shows on out_tvalid the cycle after
// the last word.
// Reset: synchronous, active low; the block comes up idle with no ellipse.
// Stall: the result register holds while out_tready is low; the next item is
// still taken and worked, and its final word waits until the register frees.
module midpoint_ellipse_rasterizer import mer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // center_x, center_y, radius_x, radius_y, zero pad
  input  logic                  in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // right_col, left_col, lower_row, upper_row
  output logic                  out_tuser,  // valid_res
  output logic                  out_tlast   // last
);

  // unpack input item
  logic [COORD_BITS-1:0]  in_cx, in_cy;
  logic [RADIUS_BITS-1:0] in_rx, in_ry;
  assign in_cx = in_tdata[COORD_BITS-1:0];
  assign in_cy = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_rx = in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
  assign in_ry = in_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];

  logic                  busy_r, busy_nxt;
  logic [UA_W-1:0]       upc_r, upc_nxt;
  logic                  active_r, active_nxt;
  logic [COORD_BITS-1:0] cx_r, cy_r;

  // result waiting for the output register
  logic                  res_vld_r;
  logic [OUT_W-1:0]      res_right_r, res_left_r, res_lower_r, res_upper_r;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r, out_tlast_r;

  mer_cw_t                  cw;
  mer_stat_t                stat;
  logic [OFFX_W-1:0]        off_x;
  logic signed [OFFY_W-1:0] off_y;
  logic                     in_fire, ld_start, adv_walk;
  logic                     stall, step_en, finish, jump;
  logic [OUT_W-1:0]         cx_w, cy_w, ox_w, oy_w;

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign ld_start  = in_fire && !in_tuser;
  assign adv_walk  = in_fire && in_tuser && active_r;

  assign cw      = mer_ucode(upc_r);
  // hold the final word until the result register is free
  assign stall   = cw.done && out_tvalid_r && !out_tready;
  assign step_en = busy_r && !stall;
  assign finish  = step_en && cw.done;

  always_comb begin
    case (cw.jmp)
      JMP_BR:       jump = stat.br;
      JMP_NO_ENTER: jump = !stat.enter;
      default:      jump = 1'b0;
    endcase
  end

  // sequencer: dispatch on accept, advance or branch each word, release on done
  always_comb begin
    busy_nxt   = busy_r;
    upc_nxt    = upc_r;
    active_nxt = active_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      if (!in_tuser) begin
        upc_nxt    = UA_START;
        active_nxt = 1'b1;
      end else if (!active_r) begin
        upc_nxt = UA_FIN;
      end else if (stat.r2) begin
        upc_nxt = UA_R2;
      end else begin
        upc_nxt = UA_R1;
      end
    end else if (step_en) begin
      if (cw.done) begin
        busy_nxt = 1'b0;
        // drop the walk once the group just sent ends the ellipse
        if (res_vld_r && stat.y_neg) active_nxt = 1'b0;
      end else if (jump) begin
        upc_nxt = cw.target;
      end else begin
        upc_nxt = upc_r + UA_W'(1);
      end
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (finish) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      upc_r        <= UA_START;
      active_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      res_vld_r    <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      upc_r        <= upc_nxt;
      active_r     <= active_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (in_fire) res_vld_r <= adv_walk;
    end
  end

  // mirror points of the offset before the step, wrapped to the output width
  assign cx_w = OUT_W'(cx_r);
  assign cy_w = OUT_W'(cy_r);
  assign ox_w = OUT_W'(off_x);
  assign oy_w = {{(OUT_W-OFFY_W){off_y[OFFY_W-1]}}, off_y};

  always_ff @(posedge clk) begin
    if (ld_start) begin
      cx_r <= in_cx;
      cy_r <= in_cy;
    end
    if (in_fire) begin
      res_right_r <= adv_walk ? cx_w + ox_w : '0;
      res_left_r  <= adv_walk ? cx_w - ox_w : '0;
      res_lower_r <= adv_walk ? cy_w + oy_w : '0;
      res_upper_r <= adv_walk ? cy_w - oy_w : '0;
    end
    if (finish) begin
      out_tdata_r <= {res_upper_r, res_lower_r, res_left_r, res_right_r};
      out_tuser_r <= res_vld_r;
      out_tlast_r <= res_vld_r && stat.y_neg;
    end
  end

  mer_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_start (ld_start),
    .radius_x (in_rx),
    .radius_y (in_ry),
    .step_en  (step_en),
    .cw       (cw),
    .off_x    (off_x),
    .off_y    (off_y),
    .stat     (stat)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // a final group is always a real point group
  a_last_is_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last set on an empty result");

  // empty results carry no coordinates
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("empty result with coordinates");

  // the program counter stays inside the control store
  a_upc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> upc_r <= UA_FIN)
    else $error("sequencer left the control store");

  // the done word releases the sequencer and presents the result
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> !busy_r && out_tvalid_r)
    else $error("done word did not hand over the result");

endmodule

### sv/mer_datapath.sv
// Datapath of the ellipse rasterizer: radii, offsets, decision, one multiplier.
// Driven word by word from the control store; depends on mer_pkg.
module mer_datapath import mer_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ld_start,
  input  logic [RADIUS_BITS-1:0]   radius_x,
  input  logic [RADIUS_BITS-1:0]   radius_y,
  input  logic                     step_en,
  input  mer_cw_t                  cw,
  output logic [OFFX_W-1:0]        off_x,
  output logic signed [OFFY_W-1:0] off_y,
  output mer_stat_t                stat
);

  logic [RADIUS_BITS-1:0]   rx_r, ry_r;
  logic [R2_W-1:0]          rx2_r, ry2_r;
  logic [OFFX_W-1:0]        x_r, x_nxt;
  logic signed [OFFY_W-1:0] y_r, y_nxt;
  logic signed [D_W-1:0]    d_r, d_nxt;
  logic signed [P_W-1:0]    p_r, q_r;
  logic                     br_r, br_nxt;
  logic                     r2_r, r2_nxt;

  logic signed [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]         mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic signed [D_W-1:0]             src_val, src_sh;
  logic signed [OFFY_W-1:0]          ty;
  logic [OFFX_W+1:0]                 tx;
  logic                              d_neg, d_zero;

  assign tx     = {1'b0, x_r, 1'b1};
  assign ty     = y_r - OFFY_W'(1);
  assign d_neg  = d_r[D_W-1];
  assign d_zero = (d_r == '0);

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cw.mul)
      MUL_NONE:    ;
      MUL_RX_RX:   begin
        mul_a = MUL_A_W'(rx_r); mul_b = MUL_B_W'(rx_r);
      end
      MUL_RY_RY:   begin
        mul_a = MUL_A_W'(ry_r); mul_b = MUL_B_W'(ry_r);
      end
      MUL_RX2_RY:  begin
        mul_a = MUL_A_W'(rx2_r); mul_b = MUL_B_W'(ry_r);
      end
      MUL_RY2_X:   begin
        mul_a = MUL_A_W'(ry2_r); mul_b = MUL_B_W'(x_r);
      end
      MUL_RX2_Y:   begin
        mul_a = MUL_A_W'(rx2_r);
        mul_b = {{(MUL_B_W-OFFY_W){y_r[OFFY_W-1]}}, y_r};
      end
      MUL_RY2_TX:  begin
        mul_a = MUL_A_W'(ry2_r); mul_b = MUL_B_W'(tx);
      end
      MUL_P_TX:    begin
        mul_a = p_r[MUL_A_W-1:0]; mul_b = MUL_B_W'(tx);
      end
      MUL_RX2_TY:  begin
        mul_a = MUL_A_W'(rx2_r);
        mul_b = {{(MUL_B_W-OFFY_W){ty[OFFY_W-1]}}, ty};
      end
      MUL_P_TY:    begin
        mul_a = p_r[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-OFFY_W){ty[OFFY_W-1]}}, ty};
      end
      MUL_RX2_RY2: begin
        mul_a = MUL_A_W'(rx2_r); mul_b = MUL_B_W'(ry2_r);
      end
      default:     ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (cw.src)
      SRC_RX2: src_val = {{(D_W-R2_W){1'b0}}, rx2_r};
      SRC_RY2: src_val = {{(D_W-R2_W){1'b0}}, ry2_r};
      default: src_val = p_r;
    endcase
    src_sh = src_val <<< cw.sh;
  end

  always_comb begin
    d_nxt = d_r;
    unique case (cw.acc)
      ACC_NONE: ;
      ACC_CLR:  d_nxt = '0;
      ACC_ADD:  d_nxt = d_r + src_sh;
      ACC_SUB:  d_nxt = d_r - src_sh;
      default:  ;
    endcase
  end

  // offset step; latch the branch taken for the update words that follow
  always_comb begin
    x_nxt  = x_r;
    y_nxt  = y_r;
    br_nxt = br_r;
    r2_nxt = r2_r;
    unique case (cw.xy)
      XY_NONE:  ;
      XY_R1:    begin
        x_nxt  = x_r + OFFX_W'(1);
        br_nxt = d_neg;
        if (!d_neg) y_nxt = y_r - OFFY_W'(1);
      end
      XY_R2:    begin
        y_nxt  = y_r - OFFY_W'(1);
        br_nxt = !d_neg && !d_zero;
        if (d_neg || d_zero) x_nxt = x_r + OFFX_W'(1);
      end
      XY_ENTER: r2_nxt = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_r <= 1'b0;
    end else if (ld_start) begin
      r2_r <= 1'b0;
    end else if (step_en) begin
      r2_r <= r2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_start) begin
      rx_r <= radius_x;
      ry_r <= radius_y;
      x_r  <= '0;
      y_r  <= {2'b00, radius_y};
      d_r  <= '0;
    end else if (step_en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      d_r  <= d_nxt;
      br_r <= br_nxt;
      if (cw.mul != MUL_NONE) p_r <= prod[P_W-1:0];
      if (cw.ld_q) q_r <= p_r;
      if (cw.ld_rx2) rx2_r <= p_r[R2_W-1:0];
      if (cw.ld_ry2) ry2_r <= p_r[R2_W-1:0];
    end
  end

  assign off_x      = x_r;
  assign off_y      = y_r;
  assign stat.r2    = r2_r;
  assign stat.br    = br_r;
  assign stat.enter = !y_r[OFFY_W-1] && (q_r > p_r);
  assign stat.y_neg = y_r[OFFY_W-1];

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for midpoint_ellipse_rasterizer: streams start and advance items and
// checks each point group against a cycle-free model of the walk kept here.
// Depends on mer_pkg and the rasterizer RTL only.
module testbench;
  import mer_pkg::*;

  localparam logic MODE_START = 1'b0;   // in_tuser: latch center and radii
  localparam logic MODE_STEP  = 1'b1;   // in_tuser: emit four points, then step

  localparam int RANDOM_ITEMS = 700;
  localparam int FULL_WALK    = 1 << 20;  // step count that always reaches the end
  localparam int LONG_HOLD    = 400;      // cycles of receiver back-pressure
  localparam int HOLD_AT      = 200;      // result count that triggers it
  localparam int SETTLE       = 40;       // cycles after the last result
  localparam int CYCLE_LIMIT  = 400000;

  // one input item, fields as the block sees them
  typedef struct packed {
    logic       mode;
    logic [9:0] cx;
    logic [9:0] cy;
    logic [8:0] rx;
    logic [8:0] ry;
  } ellipse_cmd_t;

  // one result item
  typedef struct packed {
    logic             on_curve;
    logic [OUT_W-1:0] right_col;
    logic [OUT_W-1:0] left_col;
    logic [OUT_W-1:0] lower_row;
    logic [OUT_W-1:0] upper_row;
    logic             last;
  } point_group_t;

  // walk state; decision is held at four times the textbook value
  typedef struct packed {
    logic        active;
    logic        in_r2;
    logic [9:0]  off_x;
    logic [10:0] off_y;    // two's complement, reaches -1 at the end
    longint      decision;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [8:0]  rx;
    logic [8:0]  ry;
  } walk_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  ellipse_cmd_t drive_cmd = '0;
  ellipse_cmd_t cmd_q[$];       // items waiting to be offered
  point_group_t point_q[$];     // point groups predicted, not yet seen
  point_group_t next_point;
  point_group_t want;
  walk_t        plan_walk;      // walk as planned while building stimulus
  walk_t        track_walk;     // walk as driven into the block

  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int walks_done = 0;
  int ellipses_started = 0;
  int planned_items = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;
  int cycles = 0;

  // tdata: center_x, center_y, radius_x, radius_y, two zero pad bits
  assign in_tdata = {2'b00, drive_cmd.ry, drive_cmd.rx, drive_cmd.cy, drive_cmd.cx};
  assign in_tuser = drive_cmd.mode;

  midpoint_ellipse_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the walk by one item and give the point group it produces.
  task automatic step_walk(inout walk_t w, input ellipse_cmd_t c, output point_group_t g);
    longint rx2, ry2, x, y, d, tx, ty;
    g = '0;
    if (c.mode == MODE_START) begin
      // latch parameters and sit at the top of the ellipse, region one
      w.cx = c.cx;
      w.cy = c.cy;
      w.rx = c.rx;
      w.ry = c.ry;
      rx2 = longint'(c.rx) * longint'(c.rx);
      ry2 = longint'(c.ry) * longint'(c.ry);
      w.off_x = '0;
      w.off_y = {2'b00, c.ry};
      w.in_r2 = 1'b0;
      w.decision = 4 * ry2 - 4 * rx2 * longint'(c.ry) + rx2;
      w.active = 1'b1;
    end else if (w.active) begin
      x = longint'(w.off_x);
      y = longint'(signed'(w.off_y));
      d = w.decision;
      rx2 = longint'(w.rx) * longint'(w.rx);
      ry2 = longint'(w.ry) * longint'(w.ry);
      // four mirror points of the current offset, wrapped to 12 bits
      g.on_curve  = 1'b1;
      g.right_col = OUT_W'(longint'(w.cx) + x);
      g.left_col  = OUT_W'(longint'(w.cx) - x);
      g.lower_row = OUT_W'(longint'(w.cy) + y);
      g.upper_row = OUT_W'(longint'(w.cy) - y);
      if (!w.in_r2) begin
        x = x + 1;
        if (d < 0) begin
          d = d + 8 * ry2 * x + 4 * ry2;
        end else begin
          y = y - 1;
          d = d + 8 * ry2 * x - 8 * rx2 * y + 4 * ry2;
        end
        // slope passed -1: rebuild the decision at the region-two midpoint
        if (y >= 0 && ry2 * x > rx2 * y) begin
          tx = 2 * x + 1;
          ty = y - 1;
          w.in_r2 = 1'b1;
          d = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
        end
      end else begin
        y = y - 1;
        if (d > 0) begin
          d = d + 4 * rx2 - 8 * rx2 * y;
        end else begin
          x = x + 1;
          d = d + 8 * ry2 * x - 8 * rx2 * y + 4 * rx2;
        end
      end
      // the walk ends as soon as y drops below zero, in either region
      if (y < 0) begin
        g.last = 1'b1;
        w.active = 1'b0;
      end
      w.off_x = 10'(x);
      w.off_y = 11'(y);
      w.decision = d;
    end
  endtask

  // Item with random payload; advances ignore the payload anyway.
  function automatic ellipse_cmd_t junk_cmd(input logic mode);
    ellipse_cmd_t c;
    c.mode = mode;
    c.cx = 10'($urandom);
    c.cy = 10'($urandom);
    c.rx = 9'($urandom);
    c.ry = 9'($urandom);
    return c;
  endfunction

  // Queue one item and track the planned walk so whole ellipses can be sent.
  task automatic queue_item(input ellipse_cmd_t c, output logic ended);
    point_group_t g;
    if (c.mode == MODE_START || plan_walk.active) planned_items++;
    step_walk(plan_walk, c, g);
    cmd_q.push_back(c);
    ended = g.last;
  endtask

  // Start an ellipse and advance it up to max_steps times or to its end.
  task automatic queue_ellipse(input logic [9:0] cx, input logic [9:0] cy,
                               input logic [8:0] rx, input logic [8:0] ry,
                               input int max_steps);
    ellipse_cmd_t c;
    logic ended;
    int n;
    c = '{mode: MODE_START, cx: cx, cy: cy, rx: rx, ry: ry};
    queue_item(c, ended);
    ended = 1'b0;
    n = 0;
    while (!ended && n < max_steps) begin
      queue_item(junk_cmd(MODE_STEP), ended);
      n++;
    end
  endtask

  // Per-item idle draw from the range 0 to 9, with occasional runs of no idling.
  task automatic draw_wait(inout int calm, output int n);
    if (calm > 0) begin
      calm--;
      n = 0;
    end else begin
      n = $urandom_range(0, 9);
      if ($urandom_range(0, 29) == 0) calm = $urandom_range(15, 40);
    end
  endtask

  task automatic check_field(input string what, input logic [OUT_W-1:0] exp_v,
                             input logic [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, exp_v, act_v);
    end
  endtask

  // Driver: offer queued items, honor the drawn gap after each one, and
  // predict every item at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (drive_cmd.mode == MODE_START) ellipses_started++;
        step_walk(track_walk, drive_cmd, next_point);
        point_q.push_back(next_point);
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          drive_cmd <= cmd_q.pop_front();
          in_tvalid <= 1'b1;
          draw_wait(send_calm, send_gap);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each taken result with the oldest prediction, then
  // hold off for a drawn number of cycles; once, hold off for a long stretch
  // so the block backs up and drops in_tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (point_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result tdata %h tuser %b tlast %b", $time,
                   out_tdata, out_tuser, out_tlast);
        end else begin
          want = point_q.pop_front();
          check_field("valid_res", OUT_W'(want.on_curve), OUT_W'(out_tuser));
          check_field("right_col", want.right_col, out_tdata[OUT_W-1:0]);
          check_field("left_col",  want.left_col,  out_tdata[2*OUT_W-1:OUT_W]);
          check_field("lower_row", want.lower_row, out_tdata[3*OUT_W-1:2*OUT_W]);
          check_field("upper_row", want.upper_row, out_tdata[4*OUT_W-1:3*OUT_W]);
          check_field("last",      OUT_W'(want.last), OUT_W'(out_tlast));
          if (want.last) walks_done++;
        end
        checked++;
        if (checked == HOLD_AT) recv_hold = LONG_HOLD;
        else draw_wait(recv_calm, recv_hold);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_tready <= (recv_hold == 0);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[midpoint_ellipse_rasterizer] ERROR");
      $finish;
    end
  end

  initial begin
    int pick;
    int goal;
    logic ended;
    logic [8:0] rx, ry;

    plan_walk = '0;
    track_walk = '0;

    // Directed: advance with no ellipse, both radii zero, extreme centers and
    // radii with coordinate wrap, each single radius zero, an abandoned walk,
    // and a tiny ellipse that enters region two on its first step.
    queue_item(junk_cmd(MODE_STEP), ended);
    queue_ellipse(10'd0, 10'd0, 9'd0, 9'd0, FULL_WALK);
    queue_item(junk_cmd(MODE_STEP), ended);
    queue_ellipse(10'd1023, 10'd1023, 9'd511, 9'd511, 4);
    queue_ellipse(10'd0, 10'd1023, 9'd511, 9'd1, 3);
    queue_ellipse(10'd1023, 10'd0, 9'd0, 9'd2, FULL_WALK);
    queue_ellipse(10'd512, 10'd512, 9'd2, 9'd0, FULL_WALK);
    queue_ellipse(10'd5, 10'd5, 9'd1, 9'd1, FULL_WALK);

    // Random: mostly complete small ellipses, some large ones cut short by
    // the next start, a few medium ones walked out, and a little noise.
    goal = planned_items + RANDOM_ITEMS;
    while (planned_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        rx = ($urandom_range(0, 19) == 0) ? 9'd0 : 9'($urandom_range(1, 24));
        ry = ($urandom_range(0, 19) == 0) ? 9'd0 : 9'($urandom_range(1, 24));
        queue_ellipse(10'($urandom), 10'($urandom), rx, ry, FULL_WALK);
        if ($urandom_range(0, 4) == 0) queue_item(junk_cmd(MODE_STEP), ended);
      end else if (pick < 86) begin
        queue_ellipse(10'($urandom), 10'($urandom), 9'($urandom_range(1, 511)),
                      9'($urandom_range(1, 511)), $urandom_range(1, 30));
      end else if (pick < 92) begin
        queue_ellipse(10'($urandom), 10'($urandom), 9'($urandom_range(25, 60)),
                      9'($urandom_range(25, 60)), FULL_WALK);
      end else begin
        repeat ($urandom_range(1, 3))
          queue_item(junk_cmd(($urandom_range(0, 3) == 0) ? MODE_START : MODE_STEP), ended);
      end
    end
    goal = cmd_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so the other processes have settled.
    while (accepted < goal || point_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d items (%0d ellipse starts), checked %0d point groups,",
             accepted, ellipses_started, checked);
    $display("%0d walks run to their last group, one %0d-cycle output stall.",
             walks_done, LONG_HOLD);
    if (errors == 0) begin
      $display("[midpoint_ellipse_rasterizer] OK");
    end else begin
      $display("[midpoint_ellipse_rasterizer] ERROR");
    end
    $finish;
  end

endmodule
